// ===== hw/rtl/mlfsj_pkg.sv =====
// Shared codes and widths for the multi-line join-shortest-queue FIFO bank.
// No dependencies; imported by the top level.
package mlfsj_pkg;

  localparam int OP_W     = 2;
  localparam int LINE_W   = 3;
  localparam int CUST_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;
  localparam int CFG_W    = 4;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_APPEND_SHORT = 2'd0;
  localparam op_t OP_APPEND_LINE  = 2'd1;
  localparam op_t OP_REMOVE       = 2'd2;
  localparam op_t OP_QUERY        = 2'd3;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_UNUSED = 2'd3;

  localparam logic [CFG_W-1:0] LINES_RESET = 4'd8;

endpackage

// ===== hw/rtl/multi_line_fifo_shortest_join_top.sv =====
// Customer FIFO bank: join-shortest-queue append, named append, remove and query.
// Depends on mlfsj_pkg for op and status codes and port widths.
// out_valid is a one-cycle strobe in the cycle after the accepting edge.
// Throughput: one operation per cycle; busy stays low, set by the single
// registered pass through the count tree and the store's write/read port.
// Reset (rst_n low, synchronous): all queues empty, lines_in_use back to 8,
// no result pending. The store itself is not cleared. The receiver cannot stall.
module multi_line_fifo_shortest_join_top
  import mlfsj_pkg::*;
#(
  parameter int NUM_LINES  = 8,
  parameter int LINE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [LINE_W-1:0]   in_line,
  input  logic [CUST_W-1:0]   in_customer_id,
  output logic                out_valid,
  output logic [LINE_W-1:0]   out_served_line,
  output logic [CUST_W-1:0]   out_customer_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEN_W-1:0]    out_line_length,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int PW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int AW = LW + PW;
  localparam int P  = 1 << $clog2(NUM_LINES);

  logic [CFG_W-1:0] lines_r;
  logic [PW-1:0]    head_r [NUM_LINES];
  logic [PW-1:0]    tail_r [NUM_LINES];
  logic [CW-1:0]    cnt_r  [NUM_LINES];
  logic [CUST_W-1:0] mem [1 << AW];
  logic [CUST_W-1:0] rd_r;

  logic              valid_r;
  logic              pop_r;
  logic [LINE_W-1:0] line_r;
  status_t           status_r;
  logic [LEN_W-1:0]  len_r;

  logic        accept;
  logic [5:0]  n_eff;

  // Minimum tree over active counts, heap layout, leaves at P..2P-1
  logic [CW-1:0] node_cnt [2*P];
  logic [LW-1:0] node_idx [2*P];
  logic          node_ok  [2*P];

  logic [LW-1:0] q;
  logic          unused;
  logic [CW-1:0] cur_cnt;
  logic [PW-1:0] cur_head;
  logic [PW-1:0] cur_tail;
  logic          do_push;
  logic          do_pop;
  status_t       status_nxt;
  logic [CW-1:0] len_nxt;
  logic [LINE_W-1:0] line_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (lines_r == '0) begin
      n_eff = 6'd1;
    end else if ({2'b00, lines_r} > 6'(NUM_LINES)) begin
      n_eff = 6'(NUM_LINES);
    end else begin
      n_eff = {2'b00, lines_r};
    end
  end

  always_comb begin
    for (int i = 0; i < 2*P; i++) begin
      node_cnt[i] = '0;
      node_idx[i] = '0;
      node_ok[i]  = 1'b0;
    end
    for (int i = 0; i < P; i++) begin
      if (i < NUM_LINES) begin
        node_cnt[P+i] = cnt_r[i];
        node_ok[P+i]  = (i < int'(n_eff));
      end
      node_idx[P+i] = LW'(i);
    end
    // take the right child only when strictly shorter, so the lower index wins ties
    for (int i = P - 1; i >= 1; i--) begin
      if (node_ok[2*i+1] && (!node_ok[2*i] || node_cnt[2*i+1] < node_cnt[2*i])) begin
        node_cnt[i] = node_cnt[2*i+1];
        node_idx[i] = node_idx[2*i+1];
        node_ok[i]  = 1'b1;
      end else begin
        node_cnt[i] = node_cnt[2*i];
        node_idx[i] = node_idx[2*i];
        node_ok[i]  = node_ok[2*i];
      end
    end
  end

  always_comb begin
    unused   = (in_op != OP_APPEND_SHORT) && ({3'b000, in_line} >= n_eff);
    q        = (in_op == OP_APPEND_SHORT) ? node_idx[1] : LW'(in_line);
    cur_cnt  = '0;
    cur_head = '0;
    cur_tail = '0;
    if (int'(q) < NUM_LINES) begin
      cur_cnt  = cnt_r[q];
      cur_head = head_r[q];
      cur_tail = tail_r[q];
    end
    do_push    = 1'b0;
    do_pop     = 1'b0;
    status_nxt = ST_OK;
    len_nxt    = cur_cnt;
    line_nxt   = (in_op == OP_APPEND_SHORT) ? LINE_W'(q) : in_line;
    unique case (in_op) inside
      OP_APPEND_SHORT, OP_APPEND_LINE: begin
        if (cur_cnt == CW'(LINE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          do_push = 1'b1;
          len_nxt = cur_cnt + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cur_cnt == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_pop  = 1'b1;
          len_nxt = cur_cnt - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (unused) begin
      do_push    = 1'b0;
      do_pop     = 1'b0;
      status_nxt = ST_UNUSED;
      len_nxt    = '0;
    end
    if (!accept) begin
      do_push = 1'b0;
      do_pop  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r <= LINES_RESET;
      valid_r <= 1'b0;
      pop_r   <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        lines_r <= cfg_wdata;
      end
      valid_r <= accept;
      pop_r   <= do_pop;
      // advance the pointer that moved and step the count
      if (do_push) begin
        tail_r[q] <= (cur_tail == PW'(LINE_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
        cnt_r[q]  <= cur_cnt + 1'b1;
      end
      if (do_pop) begin
        head_r[q] <= (cur_head == PW'(LINE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
        cnt_r[q]  <= cur_cnt - 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    line_r   <= line_nxt;
    status_r <= status_nxt;
    len_r    <= LEN_W'(len_nxt);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[{q, cur_tail}] <= in_customer_id;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[{q, cur_head}];
  end

  assign out_valid        = valid_r;
  assign out_served_line  = line_r;
  assign out_status       = status_r;
  assign out_line_length  = len_r;
  assign out_customer_out = pop_r ? rd_r : '0;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transfer produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !out_valid)
    else $error("result without an accepted transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY || out_status == ST_UNUSED))
      |-> (out_line_length == '0 && out_customer_out == '0))
    else $error("empty or unused result carries data");

endmodule
